// ===== rtl/bcvg_pkg.sv =====
// bcvg_pkg: constants, request/vertex types and the binomial table for the
// bezier curve vertex generator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bcvg_pkg;

  localparam int MAX_POINTS = 8;
  localparam int PT_IDX_W   = $clog2(MAX_POINTS);
  localparam int PT_CNT_W   = $clog2(MAX_POINTS + 1);

  localparam int COORD_W = 16;
  localparam int VTX_W   = 24;
  localparam int FRAC_W  = 8;

  localparam int VCNT_W = 6;
  localparam logic [VCNT_W-1:0] VCNT_RESET = VCNT_W'(16);

  // curve parameter in Q1.16, 0..1 inclusive
  localparam int Q_W     = 17;
  localparam int FRAC_Q  = 16;
  localparam int QPROD_W = 2 * Q_W;
  localparam logic [Q_W-1:0] ONE_Q16 = Q_W'(65536);

  // wide enough for any binomial coefficient with up to 16 points
  localparam int BINOM_W = 13;
  localparam int WGT_W   = BINOM_W + Q_W;
  // only the low 32 bits of the weighted sum reach the output
  localparam int ACC_W   = 32;

  typedef logic [MAX_POINTS-1:0][MAX_POINTS-1:0][BINOM_W-1:0] binom_tab_t;

  function automatic binom_tab_t build_binom();
    binom_tab_t tab;
    tab = '0;
    for (int r = 0; r < MAX_POINTS; r++) begin
      tab[r][0] = BINOM_W'(1);
      for (int c = 1; c <= r; c++) begin
        tab[r][c] = tab[r-1][c-1] + ((c < r) ? tab[r-1][c] : BINOM_W'(0));
      end
    end
    return tab;
  endfunction

  // pascal triangle, row = degree, column = point index
  localparam binom_tab_t BINOM_TAB = build_binom();

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      last_point;
  } point_req_t;

  typedef struct packed {
    logic signed [VTX_W-1:0] vertex_x;
    logic signed [VTX_W-1:0] vertex_y;
    logic                    last_vertex;
    logic                    overflow_points;
  } vertex_t;

endpackage

`default_nettype wire

// ===== rtl/bcvg_div.sv =====
// bcvg_div: restoring divider that splits 1.0 (Q1.16) by the segment count,
// one quotient bit per cycle. Depends on bcvg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bcvg_div import bcvg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [VCNT_W-1:0] divisor,
  output logic              busy,
  output logic [Q_W-1:0]    quo,
  output logic [VCNT_W-1:0] rem
);

  localparam int STEP_W = $clog2(Q_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(Q_W - 1);

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic [Q_W-1:0]    dvd_r;
  logic [Q_W-1:0]    quo_r;
  logic [VCNT_W-1:0] rem_r;

  logic [VCNT_W:0]   rem_sh;
  logic [VCNT_W:0]   rem_diff;
  logic              fits;
  logic [VCNT_W-1:0] rem_nxt;

  always_comb begin
    rem_sh   = {rem_r, dvd_r[Q_W-1]};
    fits     = rem_sh >= {1'b0, divisor};
    rem_diff = rem_sh - {1'b0, divisor};
    // partial remainder stays below the divisor
    rem_nxt  = fits ? rem_diff[VCNT_W-1:0] : rem_sh[VCNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + STEP_W'(1);
      if (step_r == LAST_STEP) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= ONE_Q16;
      quo_r <= '0;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[Q_W-2:0], 1'b0};
      quo_r <= {quo_r[Q_W-2:0], fits};
      rem_r <= rem_nxt;
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

// ===== rtl/bezier_curve_vertex_generator_core.sv =====
// Control points are requested one per cycle with start while busy is low; an
// ordinary point is stored and busy stays low. The point flagged last raises
// busy until the whole curve is out. Vertex 0 is read in the V0RD state and
// registered in V0OUT after that request; then, after the divider that sets
// the step of t, each further vertex takes a power pass and a term pass over
// the point and power memories, one entry a cycle, plus the five-stage
// multiply pipeline. Each vertex is shown for one cycle with out_strobe and
// cannot be held off, so the receiver must take it. Points beyond the store
// size are dropped and flagged on the curve.
// Depends on bcvg_pkg and bcvg_div.
`timescale 1ns / 1ps
`default_nettype none

module bezier_curve_vertex_generator_core import bcvg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  point_req_t        in_point,
  output logic              out_strobe,
  output vertex_t           out_vertex,
  input  logic              cfg_we,
  input  logic [VCNT_W-1:0] cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_V0RD  = 3'd1;
  localparam logic [2:0] S_V0OUT = 3'd2;
  localparam logic [2:0] S_DIVW  = 3'd3;
  localparam logic [2:0] S_TSTEP = 3'd4;
  localparam logic [2:0] S_SPOW  = 3'd5;
  localparam logic [2:0] S_TERM  = 3'd6;
  localparam logic [2:0] S_DRAIN = 3'd7;

  localparam int PT_W  = 2 * COORD_W;
  localparam int MUL_W = WGT_W + 1 + COORD_W;

  // memories
  logic [PT_W-1:0] pt_mem [MAX_POINTS];
  logic [Q_W-1:0]  sp_mem [MAX_POINTS];
  logic [PT_W-1:0] pt_rd_r;
  logic [Q_W-1:0]  sp_rd_r;
  logic [PT_IDX_W-1:0] pt_raddr;
  logic [PT_IDX_W-1:0] sp_raddr;

  // control
  logic [2:0]          state_r;
  logic [2:0]          state_nxt;
  logic [VCNT_W-1:0]   vcnt_cfg_r;
  logic [PT_CNT_W-1:0] count_r;
  logic                dropped_r;
  logic [PT_IDX_W-1:0] n_r;
  logic [VCNT_W-1:0]   vc_r;
  logic [VCNT_W-1:0]   j_r;
  logic [PT_IDX_W-1:0] k_r;
  logic [PT_IDX_W-1:0] i_r;

  logic                accept;
  logic                store_full;
  logic [PT_CNT_W-1:0] cnt_after;
  logic [PT_CNT_W-1:0] n_wide;
  logic [VCNT_W-1:0]   vc_eff;
  logic                div_start;
  logic                div_busy;
  logic [Q_W-1:0]      div_quo;
  logic [VCNT_W-1:0]   div_rem;

  // curve parameter stepping
  logic [Q_W-1:0]    t_r;
  logic [Q_W-1:0]    s_r;
  logic [VCNT_W-1:0] trem_r;
  logic [VCNT_W:0]   rem_sum;
  logic [VCNT_W:0]   rem_wrap;
  logic              wrap;
  logic [Q_W-1:0]    t_nxt;
  logic [VCNT_W-1:0] trem_nxt;

  // power chains
  logic [Q_W-1:0]     sp_r;
  logic [Q_W-1:0]     tp_r;
  logic [QPROD_W-1:0] sp_mul;
  logic [QPROD_W-1:0] tp_mul;

  // term pipeline
  logic                v1_r, v2_r, v3_r, v4_r;
  logic [Q_W-1:0]      tp1_r;
  logic [BINOM_W-1:0]  bin1_r, bin2_r;
  logic [QPROD_W-1:0]  prod2_r;
  logic [PT_W-1:0]     pt2_r, pt3_r;
  logic [WGT_W-1:0]    w3_r;
  logic signed [MUL_W-1:0] mx_full, my_full;
  logic [ACC_W-1:0]    mx4_r, my4_r;
  logic [ACC_W-1:0]    accx_r, accy_r;
  logic                pipe_busy;

  logic    out_strobe_r;
  vertex_t out_vertex_r;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start & ~busy;
  assign store_full = (count_r == PT_CNT_W'(MAX_POINTS));
  assign cnt_after  = store_full ? count_r : count_r + PT_CNT_W'(1);
  assign n_wide     = cnt_after - PT_CNT_W'(1);
  assign vc_eff     = (vcnt_cfg_r == '0) ? VCNT_W'(1) : vcnt_cfg_r;
  assign div_start  = (state_r == S_V0RD);
  assign pipe_busy  = v1_r | v2_r | v3_r | v4_r;

  bcvg_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (vc_r),
    .busy    (div_busy),
    .quo     (div_quo),
    .rem     (div_rem)
  );

  // t_j = floor(j / vc) in Q1.16, stepped by quotient plus carried remainder
  always_comb begin
    rem_sum  = {1'b0, trem_r} + {1'b0, div_rem};
    wrap     = rem_sum >= {1'b0, vc_r};
    rem_wrap = rem_sum - {1'b0, vc_r};
    t_nxt    = t_r + div_quo + Q_W'(wrap);
    trem_nxt = wrap ? rem_wrap[VCNT_W-1:0] : rem_sum[VCNT_W-1:0];
  end

  assign sp_mul = sp_r * s_r;
  assign tp_mul = tp_r * t_r;

  assign pt_raddr = (state_r == S_TERM) ? i_r : '0;
  assign sp_raddr = n_r - i_r;

  // memories
  always_ff @(posedge clk) begin
    if (accept && !store_full) begin
      pt_mem[count_r[PT_IDX_W-1:0]] <= {in_point.point_x, in_point.point_y};
    end
    pt_rd_r <= pt_mem[pt_raddr];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SPOW) begin
      sp_mem[k_r] <= sp_r;
    end
    sp_rd_r <= sp_mem[sp_raddr];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_point.last_point) begin
          state_nxt = S_V0RD;
        end
      end
      S_V0RD:  state_nxt = S_V0OUT;
      S_V0OUT: state_nxt = S_DIVW;
      S_DIVW: begin
        if (!div_busy) begin
          state_nxt = S_TSTEP;
        end
      end
      S_TSTEP: state_nxt = S_SPOW;
      S_SPOW: begin
        if (k_r == n_r) begin
          state_nxt = S_TERM;
        end
      end
      S_TERM: begin
        if (i_r == n_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = (j_r == vc_r) ? S_IDLE : S_TSTEP;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      vcnt_cfg_r   <= VCNT_RESET;
      count_r      <= '0;
      dropped_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= (state_r == S_V0OUT) || (state_r == S_DRAIN && !pipe_busy);
      if (cfg_we) begin
        vcnt_cfg_r <= cfg_wdata;
      end
      if (accept) begin
        if (store_full) begin
          dropped_r <= 1'b1;
        end else begin
          count_r <= count_r + PT_CNT_W'(1);
        end
      end
      if (state_r == S_DRAIN && !pipe_busy && j_r == vc_r) begin
        count_r   <= '0;
        dropped_r <= 1'b0;
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        vc_r   <= vc_eff;
        n_r    <= n_wide[PT_IDX_W-1:0];
        j_r    <= VCNT_W'(1);
        t_r    <= '0;
        trem_r <= '0;
      end
      S_TSTEP: begin
        t_r    <= t_nxt;
        s_r    <= ONE_Q16 - t_nxt;
        trem_r <= trem_nxt;
        sp_r   <= ONE_Q16;
        k_r    <= '0;
      end
      S_SPOW: begin
        sp_r <= sp_mul[FRAC_Q+Q_W-1:FRAC_Q];
        k_r  <= k_r + PT_IDX_W'(1);
        i_r  <= '0;
        tp_r <= ONE_Q16;
      end
      S_TERM: begin
        tp_r <= tp_mul[FRAC_Q+Q_W-1:FRAC_Q];
        i_r  <= i_r + PT_IDX_W'(1);
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          j_r <= j_r + VCNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // term pipeline: read, basis product, weight, point product, accumulate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= (state_r == S_TERM);
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign mx_full = $signed({1'b0, w3_r}) * $signed(pt3_r[PT_W-1:COORD_W]);
  assign my_full = $signed({1'b0, w3_r}) * $signed(pt3_r[COORD_W-1:0]);

  always_ff @(posedge clk) begin
    tp1_r   <= tp_r;
    bin1_r  <= BINOM_TAB[n_r][i_r];
    prod2_r <= sp_rd_r * tp1_r;
    bin2_r  <= bin1_r;
    pt2_r   <= pt_rd_r;
    w3_r    <= bin2_r * prod2_r[FRAC_Q+Q_W-1:FRAC_Q];
    pt3_r   <= pt2_r;
    mx4_r   <= mx_full[ACC_W-1:0];
    my4_r   <= my_full[ACC_W-1:0];
    if (state_r == S_TSTEP) begin
      accx_r <= '0;
      accy_r <= '0;
    end else if (v4_r) begin
      accx_r <= accx_r + mx4_r;
      accy_r <= accy_r + my4_r;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (state_r == S_V0OUT) begin
      out_vertex_r.vertex_x        <= {pt_rd_r[PT_W-1:COORD_W], FRAC_W'(0)};
      out_vertex_r.vertex_y        <= {pt_rd_r[COORD_W-1:0], FRAC_W'(0)};
      out_vertex_r.last_vertex     <= 1'b0;
      out_vertex_r.overflow_points <= dropped_r;
    end else if (state_r == S_DRAIN && !pipe_busy) begin
      // drop 8 fraction bits, rounding toward minus infinity
      out_vertex_r.vertex_x        <= accx_r[FRAC_W+VTX_W-1:FRAC_W];
      out_vertex_r.vertex_y        <= accy_r[FRAC_W+VTX_W-1:FRAC_W];
      out_vertex_r.last_vertex     <= (j_r == vc_r);
      out_vertex_r.overflow_points <= dropped_r;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_vertex = out_vertex_r;

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// tb: self-checking bench for the bezier curve vertex generator core; control
// points go in as start/busy requests, vertices are checked against a local
// fixed-point bernstein predictor. Depends on bcvg_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
  import bcvg_pkg::*;

  typedef longint unsigned ulong_t;

  // random points on top of the directed ones
  localparam int RAND_ITEMS = 86;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  point_req_t        in_point;
  logic              out_strobe;
  vertex_t           out_vertex;
  logic              cfg_we;
  logic [VCNT_W-1:0] cfg_wdata;

  // predictor copy of the block state
  logic signed [COORD_W-1:0] ctl_x [MAX_POINTS];
  logic signed [COORD_W-1:0] ctl_y [MAX_POINTS];
  int                        stored_cnt;
  bit                        points_dropped;
  logic [VCNT_W-1:0]         segments;

  vertex_t pending_vertices [$];
  vertex_t want;
  int      mismatch_cnt;
  bit      no_gaps;
  int      rand_items;

  bezier_curve_vertex_generator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_point   (in_point),
    .out_strobe (out_strobe),
    .out_vertex (out_vertex),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // q8 result: floor shift of the exact sum, kept to 24 bits
  function automatic logic [VTX_W-1:0] q8_floor(input longint acc);
    return VTX_W'(acc >>> FRAC_W);
  endfunction

  function automatic logic signed [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return '1;
      3: return '0;
      default: return COORD_W'($urandom);
    endcase
  endfunction

  // stores the point and, on the last one, queues the whole curve
  task automatic predict_curve(input point_req_t p);
    ulong_t  tpow [MAX_POINTS];
    ulong_t  spow [MAX_POINTS];
    ulong_t  t, s, b, binom;
    longint  acc_x, acc_y, w;
    int      vc, n, i, j;
    vertex_t v;
    if (stored_cnt < MAX_POINTS) begin
      ctl_x[stored_cnt] = p.point_x;
      ctl_y[stored_cnt] = p.point_y;
      stored_cnt++;
    end else begin
      points_dropped = 1'b1;
    end
    if (p.last_point) begin
      vc = (segments == '0) ? 1 : int'(segments);
      n = stored_cnt - 1;
      v.vertex_x = VTX_W'(longint'(ctl_x[0]) <<< FRAC_W);
      v.vertex_y = VTX_W'(longint'(ctl_y[0]) <<< FRAC_W);
      v.last_vertex = 1'b0;
      v.overflow_points = points_dropped;
      pending_vertices = {pending_vertices, v};
      for (j = 1; j <= vc; j++) begin
        t = (ulong_t'(j) << FRAC_Q) / ulong_t'(vc);
        s = ulong_t'(ONE_Q16) - t;
        tpow[0] = ONE_Q16;
        spow[0] = ONE_Q16;
        for (i = 1; i <= n; i++) begin
          tpow[i] = (tpow[i-1] * t) >> FRAC_Q;
          spow[i] = (spow[i-1] * s) >> FRAC_Q;
        end
        binom = 1;
        acc_x = 0;
        acc_y = 0;
        for (i = 0; i <= n; i++) begin
          b = (spow[n-i] * tpow[i]) >> FRAC_Q;
          w = longint'(binom * b);
          acc_x += w * longint'(ctl_x[i]);
          acc_y += w * longint'(ctl_y[i]);
          binom = binom * ulong_t'(n - i) / ulong_t'(i + 1);
        end
        v.vertex_x = q8_floor(acc_x);
        v.vertex_y = q8_floor(acc_y);
        v.last_vertex = (j == vc);
        pending_vertices = {pending_vertices, v};
      end
      stored_cnt = 0;
      points_dropped = 1'b0;
    end
  endtask

  // start stays high on return so back-to-back requests need no dead cycle
  task automatic send_point(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                            input logic last);
    point_req_t p;
    int         gap;
    p.point_x = x;
    p.point_y = y;
    p.last_point = last;
    gap = no_gaps ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_point <= p;
    do @(posedge clk); while (busy);
    predict_curve(p);
  endtask

  task automatic set_segments(input logic [VCNT_W-1:0] vc);
    start <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    do @(posedge clk); while (busy);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= vc;
    @(posedge clk);
    cfg_we <= 1'b0;
    segments = vc;
  endtask

  task automatic test_reset_segments();
    send_point(16'sh7fff, 16'sh8000, 1'b0);
    send_point(16'sh8000, 16'sh7fff, 1'b0);
    send_point('0, '0, 1'b1);
  endtask

  task automatic test_single_point();
    set_segments(VCNT_W'(1));
    send_point(16'sh8000, 16'sh7fff, 1'b1);
  endtask

  task automatic test_full_scale();
    int k;
    set_segments(VCNT_W'(63));
    for (k = 0; k < MAX_POINTS; k++) begin
      send_point(k[0] ? 16'sh7fff : 16'sh8000, k[0] ? 16'sh8000 : 16'sh7fff,
                 k == MAX_POINTS - 1);
    end
  endtask

  // two points past the store, both dropped, the second carrying the last flag
  task automatic test_store_overflow();
    int k;
    set_segments(VCNT_W'(5));
    for (k = 0; k < MAX_POINTS + 2; k++) begin
      send_point(rand_coord(), rand_coord(), k == MAX_POINTS + 1);
    end
  endtask

  task automatic test_zero_segments();
    set_segments('0);
    send_point('1, 16'sd1, 1'b0);
    send_point(16'sd12345, -16'sd12345, 1'b1);
  endtask

  task automatic test_random_curves();
    logic [VCNT_W-1:0] vc;
    int                phase_end, npts, k;
    while (rand_items < RAND_ITEMS) begin
      if ($urandom_range(0, 3) == 0) vc = VCNT_W'($urandom_range(32, 63));
      else vc = VCNT_W'($urandom_range(0, 12));
      set_segments(vc);
      no_gaps = ($urandom_range(0, 3) == 0);
      phase_end = rand_items + 18;
      while (rand_items < phase_end && rand_items < RAND_ITEMS) begin
        // mostly curves that fit the store, some that spill over it
        npts = ($urandom_range(0, 4) == 0) ? $urandom_range(MAX_POINTS + 1, MAX_POINTS + 4)
                                           : $urandom_range(1, MAX_POINTS);
        for (k = 0; k < npts; k++) begin
          send_point(rand_coord(), rand_coord(), k == npts - 1);
          rand_items++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_vertices.size() == 0) begin
        $error("unexpected vertex x=%0d y=%0d", out_vertex.vertex_x, out_vertex.vertex_y);
        mismatch_cnt++;
      end else begin
        want = pending_vertices.pop_front();
        if (out_vertex.vertex_x !== want.vertex_x) begin
          $error("vertex_x expected %0d actual %0d", want.vertex_x, out_vertex.vertex_x);
          mismatch_cnt++;
        end
        if (out_vertex.vertex_y !== want.vertex_y) begin
          $error("vertex_y expected %0d actual %0d", want.vertex_y, out_vertex.vertex_y);
          mismatch_cnt++;
        end
        if (out_vertex.last_vertex !== want.last_vertex) begin
          $error("last_vertex expected %0d actual %0d", want.last_vertex,
                 out_vertex.last_vertex);
          mismatch_cnt++;
        end
        if (out_vertex.overflow_points !== want.overflow_points) begin
          $error("overflow_points expected %0d actual %0d", want.overflow_points,
                 out_vertex.overflow_points);
          mismatch_cnt++;
        end
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_point = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    stored_cnt = 0;
    points_dropped = 1'b0;
    segments = VCNT_RESET;
    mismatch_cnt = 0;
    no_gaps = 1'b0;
    rand_items = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_segments();
    test_single_point();
    test_full_scale();
    test_store_overflow();
    test_zero_segments();
    test_random_curves();
    start <= 1'b0;
    while (pending_vertices.size() != 0) @(posedge clk);
    // room for any stray curve to show up
    repeat (1500) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
